FILE: rtl/core/mbct_pkg.sv
package mbct_pkg;

    localparam int TABLE_ENTRIES = 512;
    localparam int IDX_W         = (TABLE_ENTRIES > 2) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);

    localparam int MAC_W         = 48;
    localparam int TOTAL_W       = 32;
    localparam int BYTES_W       = 16;
    localparam int FIDX_W        = 9;
    localparam int FCNT_W        = 10;

    localparam int S_TDATA_W     = 128;
    localparam int M_TDATA_W     = 104;

    localparam logic [MAC_W-1:0]   BCAST_ADDR    = '1;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX     = '1;

    typedef enum logic [2:0] {
        OUT_HIT   = 3'd0,
        OUT_NEW   = 3'd1,
        OUT_BCAST = 3'd2,
        OUT_FULL  = 3'd3,
        OUT_READ  = 3'd4
    } t_outcome;

    typedef enum logic {
        OP_RECORD = 1'b0,
        OP_READ   = 1'b1
    } t_op;

    // Program addresses of the sequencer
    typedef enum logic [3:0] {
        ST_IDLE     = 4'd0,
        ST_DISPATCH = 4'd1,
        ST_BCHECK   = 4'd2,
        ST_SCAN     = 4'd3,
        ST_MISS     = 4'd4,
        ST_HIT      = 4'd5,
        ST_DROP     = 4'd6,
        ST_RD_ISSUE = 4'd7,
        ST_RD_DONE  = 4'd8,
        ST_EMIT     = 4'd9
    } t_step;

    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_REQ,
        C_OP_READ,
        C_BCAST,
        C_MATCH,
        C_SCANNING,
        C_OUT_FREE
    } t_cond;

    typedef enum logic [3:0] {
        ACT_NONE,
        ACT_LATCH,
        ACT_CLEAR,
        ACT_SCAN,
        ACT_MISS,
        ACT_HIT,
        ACT_DROP,
        ACT_RD_ISSUE,
        ACT_RD_DONE,
        ACT_EMIT
    } t_act;

    typedef struct packed {
        logic  ready;
        t_act  act;
        t_cond jmp_cond;
        t_step target;
        t_cond wait_cond;
    } t_uword;

    typedef struct packed {
        logic               valid;
        logic [FIDX_W-1:0]  idx;
        logic [MAC_W-1:0]   mac;
        logic [TOTAL_W-1:0] total;
        t_outcome           outcome;
        logic [FCNT_W-1:0]  count;
    } t_result;

    // Control store. Jump wins over repeat; otherwise fall through to the next step.
    function automatic t_uword ucode(input t_step step);
        t_uword w;
        w = '{ready: 1'b0, act: ACT_NONE, jmp_cond: C_NEVER,
              target: ST_IDLE, wait_cond: C_NEVER};
        unique case (step)
            ST_IDLE: begin
                w.ready     = 1'b1;
                w.act       = ACT_LATCH;
                w.wait_cond = C_NO_REQ;
            end
            ST_DISPATCH: begin
                w.act      = ACT_CLEAR;
                w.jmp_cond = C_OP_READ;
                w.target   = ST_RD_ISSUE;
            end
            ST_BCHECK: begin
                w.jmp_cond = C_BCAST;
                w.target   = ST_DROP;
            end
            ST_SCAN: begin
                w.act       = ACT_SCAN;
                w.jmp_cond  = C_MATCH;
                w.target    = ST_HIT;
                w.wait_cond = C_SCANNING;
            end
            ST_MISS: begin
                w.act      = ACT_MISS;
                w.jmp_cond = C_ALWAYS;
                w.target   = ST_EMIT;
            end
            ST_HIT: begin
                w.act      = ACT_HIT;
                w.jmp_cond = C_ALWAYS;
                w.target   = ST_EMIT;
            end
            ST_DROP: begin
                w.act      = ACT_DROP;
                w.jmp_cond = C_ALWAYS;
                w.target   = ST_EMIT;
            end
            ST_RD_ISSUE: begin
                w.act = ACT_RD_ISSUE;
            end
            ST_RD_DONE: begin
                w.act = ACT_RD_DONE;
            end
            ST_EMIT: begin
                w.act       = ACT_EMIT;
                w.jmp_cond  = C_OUT_FREE;
                w.target    = ST_IDLE;
                w.wait_cond = C_ALWAYS;
            end
            default: begin
                w.jmp_cond = C_ALWAYS;
                w.target   = ST_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

FILE: rtl/core/mac_byte_counter_table.sv
// Channel   | Dir | Payload (low bit first)                                  | Rule
// s_axis    | in  | tuser: operation; tdata: tx mac, rx mac, bytes, read idx | valid & ready
// m_axis    | out | tuser: outcome; tdata: valid, idx, mac, total, count     | valid & ready
// i_cfg_wr  | in  | count_transmitter                                        | write enable
//
// One request at a time. A record that misses scans every used entry, a hit on entry i
// stops after entry i: the scan reads one entry per cycle through the single memory read
// port. A read or a broadcast drop does no scan.
// Reset clears the entry count and the sequencer; table contents are not cleared.
// A result waits in the output register; the next request is taken meanwhile, and
// the sequencer only holds when a second result finds that register still full.
module mac_byte_counter_table
    import mbct_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic                 i_cfg_wr_data,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // [47:0] transmitter_mac, [95:48] receiver_mac, [111:96] pkt_len,
    // [120:112] read_index, [127:121] zero
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    // [0] operation
    input  logic                 s_axis_tuser,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // [0] entry_valid, [9:1] entry_index, [57:10] entry_mac, [89:58] entry_total,
    // [99:90] entry_count, [103:100] zero
    output logic [M_TDATA_W-1:0] m_axis_tdata,
    // [2:0] outcome
    output logic [2:0]           m_axis_tuser
);

    // table storage
    logic [MAC_W-1:0]   mem_mac   [TABLE_ENTRIES];
    logic [TOTAL_W-1:0] mem_total [TABLE_ENTRIES];

    t_step  r_pc, n_pc;
    t_uword uw;

    logic               r_count_tx;
    logic [CNT_W-1:0]   r_used;
    logic [CNT_W-1:0]   r_idx;
    logic               r_pend;
    logic [IDX_W-1:0]   r_rd_idx;
    logic [MAC_W-1:0]   r_rd_mac;
    logic [TOTAL_W-1:0] r_rd_total;
    logic               r_rd_ok;

    t_op                r_op;
    logic               r_bcast;
    logic [MAC_W-1:0]   r_key;
    logic [BYTES_W-1:0] r_bytes;
    logic [FIDX_W-1:0]  r_ridx;

    t_result            r_res;
    t_result            r_out;
    logic               r_out_valid;

    logic               accept;
    logic               match;
    logic               more;
    logic               full;
    logic               out_free;
    logic [TOTAL_W:0]   sum;
    logic [TOTAL_W-1:0] sat_sum;

    logic               mem_re;
    logic [IDX_W-1:0]   mem_ra;
    logic               mac_we;
    logic               tot_we;
    logic [IDX_W-1:0]   mem_wa;
    logic [TOTAL_W-1:0] tot_wd;

    // control word of the current step
    always_comb begin
        uw = ucode(r_pc);
    end

    assign s_axis_tready = uw.ready & i_rst_n;
    assign accept        = s_axis_tvalid & s_axis_tready;
    assign match         = r_pend && (r_rd_mac == r_key);
    assign more          = r_idx < r_used;
    assign full          = r_used >= CNT_W'(TABLE_ENTRIES);
    assign out_free      = !r_out_valid || m_axis_tready;
    assign sum           = {1'b0, r_rd_total} + (TOTAL_W + 1)'(r_bytes);
    assign sat_sum       = sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];

    function automatic logic cond_true(input t_cond c, input logic acc, input t_op op,
                                       input logic bc, input logic mt, input logic sc,
                                       input logic of);
        logic r;
        unique case (c)
            C_NEVER:    r = 1'b0;
            C_ALWAYS:   r = 1'b1;
            C_NO_REQ:   r = !acc;
            C_OP_READ:  r = (op == OP_READ);
            C_BCAST:    r = bc;
            C_MATCH:    r = mt;
            C_SCANNING: r = sc;
            C_OUT_FREE: r = of;
            default:    r = 1'b0;
        endcase
        return r;
    endfunction

    // next step
    always_comb begin
        priority if (cond_true(uw.jmp_cond, accept, r_op, r_bcast, match,
                               r_pend || more, out_free)) begin
            n_pc = uw.target;
        end else if (cond_true(uw.wait_cond, accept, r_op, r_bcast, match,
                               r_pend || more, out_free)) begin
            n_pc = r_pc;
        end else begin
            n_pc = t_step'(r_pc + 4'd1);
        end
    end

    // memory port controls
    always_comb begin
        mem_re = 1'b0;
        mem_ra = r_idx[IDX_W-1:0];
        mac_we = 1'b0;
        tot_we = 1'b0;
        mem_wa = r_rd_idx;
        tot_wd = sat_sum;
        unique case (uw.act)
            ACT_SCAN: begin
                mem_re = !match && more;
            end
            ACT_RD_ISSUE: begin
                mem_re = 1'b1;
                mem_ra = IDX_W'(r_ridx);
            end
            ACT_HIT: begin
                tot_we = 1'b1;
            end
            ACT_MISS: begin
                mac_we = !full;
                tot_we = !full;
                mem_wa = r_used[IDX_W-1:0];
                tot_wd = TOTAL_W'(r_bytes);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mac_we) begin
            mem_mac[mem_wa] <= r_key;
        end
        if (tot_we) begin
            mem_total[mem_wa] <= tot_wd;
        end
        if (mem_re) begin
            r_rd_mac   <= mem_mac[mem_ra];
            r_rd_total <= mem_total[mem_ra];
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc        <= ST_IDLE;
            r_count_tx  <= 1'b0;
            r_used      <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_pc <= n_pc;
            if (i_cfg_wr_en) begin
                r_count_tx <= i_cfg_wr_data;
            end
            if (uw.act == ACT_CLEAR) begin
                r_pend <= 1'b0;
            end else if (uw.act == ACT_SCAN && !match) begin
                r_pend <= more;
            end
            if (uw.act == ACT_MISS && !full) begin
                r_used <= r_used + CNT_W'(1);
            end
            if (uw.act == ACT_EMIT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        unique case (uw.act)
            ACT_LATCH: begin
                if (accept) begin
                    r_op    <= t_op'(s_axis_tuser);
                    r_key   <= r_count_tx ? s_axis_tdata[47:0] : s_axis_tdata[95:48];
                    r_bcast <= (s_axis_tdata[95:48] == BCAST_ADDR);
                    r_bytes <= s_axis_tdata[111:96];
                    r_ridx  <= s_axis_tdata[120:112];
                end
            end
            ACT_CLEAR: begin
                r_idx <= '0;
            end
            ACT_SCAN: begin
                // hold the pending entry on a match so the hit step sees it
                if (!match && more) begin
                    r_rd_idx <= r_idx[IDX_W-1:0];
                    r_idx    <= r_idx + CNT_W'(1);
                end
            end
            ACT_HIT: begin
                r_res <= '{valid: 1'b1, idx: FIDX_W'(r_rd_idx), mac: r_key,
                           total: sat_sum, outcome: OUT_HIT, count: FCNT_W'(r_used)};
            end
            ACT_MISS: begin
                if (full) begin
                    r_res <= '{valid: 1'b0, idx: '0, mac: '0, total: '0,
                               outcome: OUT_FULL, count: FCNT_W'(r_used)};
                end else begin
                    r_res <= '{valid: 1'b1, idx: FIDX_W'(r_used), mac: r_key,
                               total: TOTAL_W'(r_bytes), outcome: OUT_NEW,
                               count: FCNT_W'(r_used + CNT_W'(1))};
                end
            end
            ACT_DROP: begin
                r_res <= '{valid: 1'b0, idx: '0, mac: '0, total: '0,
                           outcome: OUT_BCAST, count: FCNT_W'(r_used)};
            end
            ACT_RD_ISSUE: begin
                r_rd_ok <= (32'(r_ridx) < 32'(r_used));
            end
            ACT_RD_DONE: begin
                r_res <= '{valid: r_rd_ok, idx: r_ridx,
                           mac: r_rd_ok ? r_rd_mac : '0,
                           total: r_rd_ok ? r_rd_total : '0,
                           outcome: OUT_READ, count: FCNT_W'(r_used)};
            end
            ACT_EMIT: begin
                if (out_free) begin
                    r_out <= r_res;
                end
            end
            default: begin
            end
        endcase
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'b0000, r_out.count, r_out.total, r_out.mac,
                            r_out.idx, r_out.valid};
    assign m_axis_tuser  = r_out.outcome;

endmodule

FILE: rtl/core/mbct_checker.sv
module mbct_checker
    import mbct_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 s_axis_tvalid,
    input logic                 s_axis_tready,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [M_TDATA_W-1:0] m_axis_tdata,
    input logic [2:0]           m_axis_tuser
);

    // hold a result until it is taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped before it was taken");

    // one request at a time: an accepted request closes the input for a while
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request taken while another is in work");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (32'(m_axis_tdata[99:90]) <= TABLE_ENTRIES))
        else $error("entry count beyond table size");

    // a counted packet always reports a stored entry
    a_counted_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == OUT_HIT || m_axis_tuser == OUT_NEW)
        |-> m_axis_tdata[0] && (m_axis_tdata[99:90] != '0))
        else $error("counted packet without a valid entry");

    a_dropped_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == OUT_BCAST || m_axis_tuser == OUT_FULL)
        |-> !m_axis_tdata[0] && (m_axis_tdata[89:1] == '0))
        else $error("dropped packet reports entry data");

endmodule

bind mac_byte_counter_table mbct_checker u_mbct_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

FILE: test/tb_mac_byte_counter_table.sv
module tb_mac_byte_counter_table
    import mbct_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        t_op                op;
        logic [MAC_W-1:0]   tx;
        logic [MAC_W-1:0]   rx;
        logic [BYTES_W-1:0] nbytes;
        logic [FIDX_W-1:0]  ridx;
    } t_packet_req;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_wr_en = 1'b0;
    logic                 i_cfg_wr_data = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    // [47:0] transmitter_mac, [95:48] receiver_mac, [111:96] pkt_len,
    // [120:112] read_index, [127:121] zero
    logic [S_TDATA_W-1:0] s_axis_tdata = '0;
    // [0] operation
    logic                 s_axis_tuser = 1'b0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    // [0] entry_valid, [9:1] entry_index, [57:10] entry_mac, [89:58] entry_total,
    // [99:90] entry_count, [103:100] zero
    logic [M_TDATA_W-1:0] m_axis_tdata;
    // [2:0] outcome
    logic [2:0]           m_axis_tuser;

    // Shadow of the address table
    logic [MAC_W-1:0]   mac_table [TABLE_ENTRIES];
    logic [TOTAL_W-1:0] byte_totals [TABLE_ENTRIES];
    int                 entries_held = 0;
    bit                 by_transmitter = 1'b0;

    t_result predicted_reports [$];
    int      mismatch_count = 0;

    bit tx_no_gaps = 1'b0;
    bit rx_always_ready = 1'b0;
    int hold_off_req = 0;
    int hold_left = 0;
    int stall_left = 0;

    mac_byte_counter_table u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    initial begin
        #80_000_000;
        $display("tb: failure");
        $finish;
    end

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(15, 70);
    endfunction

    function automatic logic [MAC_W-1:0] random_mac();
        logic [63:0] wide;
        wide = {$urandom(), $urandom()};
        return wide[MAC_W-1:0];
    endfunction

    function automatic t_packet_req make_record(logic [MAC_W-1:0] tx, logic [MAC_W-1:0] rx,
                                                logic [BYTES_W-1:0] nbytes);
        t_packet_req r;
        r.op     = OP_RECORD;
        r.tx     = tx;
        r.rx     = rx;
        r.nbytes = nbytes;
        r.ridx   = FIDX_W'($urandom_range(0, 511));
        return r;
    endfunction

    function automatic t_packet_req make_read(int idx);
        t_packet_req r;
        r.op     = OP_READ;
        r.tx     = random_mac();
        r.rx     = random_mac();
        r.nbytes = BYTES_W'($urandom());
        r.ridx   = FIDX_W'(idx);
        return r;
    endfunction

    // Apply one request to the shadow table and return the report it causes
    function automatic t_result table_update(t_packet_req r);
        t_result            res;
        logic [MAC_W-1:0]   key;
        logic [TOTAL_W:0]   sum;
        int                 hit;
        int                 i;
        res = '0;
        if (r.op == OP_READ) begin
            res.outcome = OUT_READ;
            res.idx     = r.ridx;
            if (r.ridx < entries_held) begin
                res.valid = 1'b1;
                res.mac   = mac_table[r.ridx];
                res.total = byte_totals[r.ridx];
            end
        end else if (r.rx == BCAST_ADDR) begin
            res.outcome = OUT_BCAST;
        end else begin
            key = by_transmitter ? r.tx : r.rx;
            hit = -1;
            for (i = 0; i < entries_held; i++) begin
                if (hit < 0 && mac_table[i] == key)
                    hit = i;
            end
            if (hit >= 0) begin
                sum = byte_totals[hit] + r.nbytes;
                if (sum > TOTAL_MAX)
                    sum = TOTAL_MAX;
                byte_totals[hit] = sum[TOTAL_W-1:0];
                res.valid   = 1'b1;
                res.idx     = FIDX_W'(hit);
                res.mac     = key;
                res.total   = sum[TOTAL_W-1:0];
                res.outcome = OUT_HIT;
            end else if (entries_held >= TABLE_ENTRIES) begin
                res.outcome = OUT_FULL;
            end else begin
                mac_table[entries_held]   = key;
                byte_totals[entries_held] = TOTAL_W'(r.nbytes);
                res.valid   = 1'b1;
                res.idx     = FIDX_W'(entries_held);
                res.mac     = key;
                res.total   = TOTAL_W'(r.nbytes);
                res.outcome = OUT_NEW;
                entries_held++;
            end
        end
        res.count = FCNT_W'(entries_held);
        return res;
    endfunction

    function automatic t_packet_req random_request();
        t_packet_req r;
        int          roll;
        int          pick;
        roll = $urandom_range(0, 99);
        pick = $urandom_range(0, 9);
        r = make_record(random_mac(), random_mac(), BYTES_W'($urandom()));
        if (pick == 0)
            r.nbytes = '0;
        else if (pick == 1)
            r.nbytes = '1;
        if (roll < 22) begin
            if ($urandom_range(0, 9) < 6)
                r = make_read($urandom_range(0, (entries_held + 1 > 511) ? 511 : entries_held + 1));
            else
                r = make_read($urandom_range(0, 511));
        end else if (roll < 27) begin
            r.rx = BCAST_ADDR;
        end else if (roll < 78 && entries_held > 0) begin
            // hit an address already held
            if (by_transmitter)
                r.tx = mac_table[$urandom_range(0, entries_held - 1)];
            else
                r.rx = mac_table[$urandom_range(0, entries_held - 1)];
        end
        return r;
    endfunction

    task automatic send_request(t_packet_req r);
        int gap;
        gap = tx_no_gaps ? 0 : pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= r.op;
        s_axis_tdata  <= {7'b0, r.ridx, r.nbytes, r.rx, r.tx};
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        predicted_reports.push_back(table_update(r));
    endtask

    // Hold the sender until every report has come back
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (predicted_reports.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic set_count_mode(bit by_tx);
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= by_tx;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        by_transmitter = by_tx;
    endtask

    task automatic test_directed_cases();
        set_count_mode(1'b0);
        send_request(make_read(0));
        send_request(make_read(511));
        send_request(make_record('0, BCAST_ADDR, '1));
        send_request(make_record('1, '0, '0));
        send_request(make_record(48'h123, '0, '1));
        send_request(make_record('1, 48'hFFFF_FFFF_FFFE, 16'd1));
        send_request(make_record(48'h5555_5555_5555, 48'hAAAA_AAAA_AAAA, 16'h5555));
        send_request(make_record(48'hAAAA_AAAA_AAAA, 48'h5555_5555_5555, 16'hAAAA));
        send_request(make_read(0));
        send_request(make_read(3));
        send_request(make_read(4));
        send_request(make_read(511));
        drain_results();
        set_count_mode(1'b1);
        // all-ones transmitter is a legal key when counting by transmitter
        send_request(make_record('1, 48'h1, '1));
        send_request(make_record('1, BCAST_ADDR, '1));
        send_request(make_record('0, 48'h7, 16'h8000));
        send_request(make_record('1, 48'h2, '1));
        send_request(make_read(4));
        send_request(make_read(5));
        drain_results();
        set_count_mode(1'b0);
    endtask

    task automatic test_backpressure();
        tx_no_gaps   = 1'b1;
        hold_off_req = 400;
        repeat (12) send_request(random_request());
        drain_results();
        tx_no_gaps = 1'b0;
    endtask

    task automatic test_random_traffic();
        int phase;
        for (phase = 0; phase < 5; phase++) begin
            drain_results();
            set_count_mode(phase[0]);
            tx_no_gaps      = (phase == 2);
            rx_always_ready = (phase == 3);
            repeat (140) send_request(random_request());
        end
        tx_no_gaps      = 1'b0;
        rx_always_ready = 1'b0;
        drain_results();
    endtask

    task automatic test_full_table();
        set_count_mode(1'b0);
        while (entries_held < TABLE_ENTRIES)
            send_request(make_record(random_mac(), random_mac(), BYTES_W'($urandom())));
        repeat (12) send_request(make_record(random_mac(), random_mac(), BYTES_W'($urandom())));
        repeat (6) send_request(make_record(random_mac(),
                                            mac_table[$urandom_range(0, TABLE_ENTRIES - 1)],
                                            BYTES_W'($urandom())));
        send_request(make_read(0));
        send_request(make_read(511));
        send_request(make_record(random_mac(), BCAST_ADDR, '1));
        drain_results();
        set_count_mode(1'b1);
        repeat (8) send_request(make_record(random_mac(), random_mac(), BYTES_W'($urandom())));
        repeat (4) send_request(make_record(mac_table[$urandom_range(0, TABLE_ENTRIES - 1)],
                                            random_mac(), BYTES_W'($urandom())));
        send_request(make_read(511));
        drain_results();
    endtask

    // Result side: random stalls, plus a counted hold-off on request
    always @(posedge i_clk) begin
        if (hold_off_req > 0) begin
            hold_left    = hold_off_req;
            hold_off_req = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else if (rx_always_ready) begin
            m_axis_tready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end else begin
            stall_left = pick_gap();
            m_axis_tready <= (stall_left == 0);
        end
    end

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.valid   = m_axis_tdata[0];
            got.idx     = m_axis_tdata[9:1];
            got.mac     = m_axis_tdata[57:10];
            got.total   = m_axis_tdata[89:58];
            got.count   = m_axis_tdata[99:90];
            got.outcome = t_outcome'(m_axis_tuser);
            if (predicted_reports.size() == 0) begin
                if (mismatch_count < 10)
                    $display({"unexpected report: valid=%0d idx=%0d mac=%h total=%h ",
                              "outcome=%0d count=%0d"},
                             got.valid, got.idx, got.mac, got.total, got.outcome, got.count);
                mismatch_count++;
            end else begin
                want = predicted_reports.pop_front();
                if (got.valid !== want.valid || got.idx !== want.idx || got.mac !== want.mac ||
                    got.total !== want.total || got.outcome !== want.outcome ||
                    got.count !== want.count) begin
                    if (mismatch_count < 10) begin
                        $display({"mismatch expected: valid=%0d idx=%0d mac=%h total=%h ",
                                  "outcome=%0d count=%0d"},
                                 want.valid, want.idx, want.mac, want.total, want.outcome,
                                 want.count);
                        $display({"         actual:   valid=%0d idx=%0d mac=%h total=%h ",
                                  "outcome=%0d count=%0d"},
                                 got.valid, got.idx, got.mac, got.total, got.outcome,
                                 got.count);
                    end
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_cases();
        test_backpressure();
        test_random_traffic();
        test_full_table();
        drain_results();
        repeat (TABLE_ENTRIES + 20) @(posedge i_clk);
        if (mismatch_count == 0 && predicted_reports.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
